>>> src/fpds_pkg.sv
// Shared types and constants for the fractional-N divider search block.
// No dependencies; every other file imports this package.
package fpds_pkg;

	// Field widths fixed by the interface
	localparam int FREQ_W  = 23;
	localparam int PFD_W   = 15;
	localparam int INT_W   = 16;
	localparam int FIELD_W = 12;
	localparam int EXP_W   = 3;
	localparam int ERR_W   = 15;

	// Frequency limits in kHz
	localparam logic [FREQ_W-1:0] VCO_MIN_KHZ   = 23'd2200000;
	localparam logic [FREQ_W-1:0] VCO_MAX_KHZ   = 23'd4400000;
	localparam logic [PFD_W-1:0]  PFD_RESET_KHZ = 15'd10000;

	// Shared divider: 23-bit dividend, 15-bit divisor, 16 quotient bits
	localparam int DIV_STEPS = INT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_INT_WAIT,
		ST_STEP,
		ST_LO_WAIT,
		ST_HI_WAIT,
		ST_DONE
	} fpds_state_t;

	// Divider request from the sequencer
	typedef struct packed {
		logic              start;
		logic [FREQ_W-1:0] dividend;
		logic [PFD_W-1:0]  divisor;
	} div_req_t;

	// Divider status and result
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [INT_W-1:0]  quotient;
		logic [PFD_W-1:0]  remainder;
	} div_rsp_t;

	// One result transaction
	typedef struct packed {
		logic [INT_W-1:0]   integer_part;
		logic [FIELD_W-1:0] fraction_value;
		logic [FIELD_W-1:0] modulus_value;
		logic [EXP_W-1:0]   divider_exponent;
		logic [ERR_W-1:0]   residual_error_khz;
		logic               out_of_range;
	} result_t;

endpackage

>>> src/fpds_if.sv
// Valid/ready channel interfaces for target requests and divider results.
// Depends on fpds_pkg for field widths.
interface fpds_req_if import fpds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] target_freq_khz;

	modport source (output valid, output target_freq_khz, input ready);
	modport sink   (input valid, input target_freq_khz, output ready);
endinterface

interface fpds_rsp_if import fpds_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INT_W-1:0]   integer_part;
	logic [FIELD_W-1:0] fraction_value;
	logic [FIELD_W-1:0] modulus_value;
	logic [EXP_W-1:0]   divider_exponent;
	logic [ERR_W-1:0]   residual_error_khz;
	logic               out_of_range;

	modport source (output valid, output integer_part, output fraction_value,
		output modulus_value, output divider_exponent, output residual_error_khz,
		output out_of_range, input ready);
	modport sink   (input valid, input integer_part, input fraction_value,
		input modulus_value, input divider_exponent, input residual_error_khz,
		input out_of_range, output ready);
endinterface

>>> src/frac_n_pll_divider_search_top.sv
// Top level of the fractional-N divider search: config register, sequencer,
// shared divider and output register. Depends on fpds_pkg, fpds_if, fpds_div, fpds_ctrl.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  req      | in  | valid/ready    | target_freq_khz
//  rsp      | out | valid/ready    | integer_part .. out_of_range
//  cfg      | in  | cfg_we         | cfg_wdata = pfd_freq_khz
//
// One transaction runs the range steps and the integer split, then for each modulus
// tried an update step and two divides on the shared divider. The sweep ends at the
// last modulus or earlier when an exact fraction is found. req.ready is high only between
// transactions; a finished result waits in the output register while the next
// request is taken. Reset (arst_n) clears control state and loads 10000 kHz.
module frac_n_pll_divider_search_top import fpds_pkg::*; #(
	parameter int MOD_LIMIT       = 4096,
	parameter int MAX_DIVIDER_EXP = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [PFD_W-1:0] cfg_wdata,
	fpds_req_if.sink         req,
	fpds_rsp_if.source       rsp
);

	logic [PFD_W-1:0] pfd_q;
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	// PFD frequency register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfd_q <= PFD_RESET_KHZ;
		end else if (cfg_we) begin
			pfd_q <= cfg_wdata;
		end
	end

	fpds_ctrl #(
		.MOD_LIMIT       (MOD_LIMIT),
		.MAX_DIVIDER_EXP (MAX_DIVIDER_EXP)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pfd       (pfd_q),
		.in_valid  (req.valid),
		.in_target (req.target_freq_khz),
		.in_ready  (req.ready),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	fpds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output register: free when empty or being taken
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.integer_part       = out_q.integer_part;
	assign rsp.fraction_value     = out_q.fraction_value;
	assign rsp.modulus_value      = out_q.modulus_value;
	assign rsp.divider_exponent   = out_q.divider_exponent;
	assign rsp.residual_error_khz = out_q.residual_error_khz;
	assign rsp.out_of_range       = out_q.out_of_range;

endmodule

>>> src/fpds_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on fpds_pkg. Caller guarantees dividend[22:16] < divisor.
module fpds_div import fpds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PFD_W-1:0]     rem_q;
	logic [INT_W-1:0]     quo_q;
	logic [PFD_W-1:0]     dvs_q;

	logic [PFD_W:0]   trial;
	logic             ge;
	logic [PFD_W-1:0] rem_next;

	// One shift-compare-subtract step
	always_comb begin
		trial    = {rem_q, quo_q[INT_W-1]};
		ge       = trial >= {1'b0, dvs_q};
		rem_next = ge ? PFD_W'(trial - {1'b0, dvs_q}) : trial[PFD_W-1:0];
	end

	// Control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= PFD_W'(req.dividend[FREQ_W-1:INT_W]);
			quo_q <= req.dividend[INT_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[INT_W-2:0], ge};
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> src/fpds_ctrl.sv
// Search sequencer: range check, integer split and modulus sweep.
// Depends on fpds_pkg; drives the shared fpds_div through div_req_t/div_rsp_t.
module fpds_ctrl import fpds_pkg::*; #(
	parameter int MOD_LIMIT       = 4096,
	parameter int MAX_DIVIDER_EXP = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PFD_W-1:0]  pfd,
	input  logic              in_valid,
	input  logic [FREQ_W-1:0] in_target,
	output logic              in_ready,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res
);

	localparam int MW = $clog2(MOD_LIMIT);

	fpds_state_t state_q, state_d;

	logic [FREQ_W-1:0] f_q;
	logic [EXP_W-1:0]  exp_q;
	logic [INT_W-1:0]  int_q;
	logic [PFD_W-1:0]  rem_q;
	logic [PFD_W-1:0]  r1_q;
	logic [MW-1:0]     m_q;
	logic [MW-1:0]     frac_q;
	logic [INT_W-1:0]  err_lo_q;
	logic [INT_W-1:0]  best_err_q;
	logic [MW-1:0]     best_m_q;
	logic [MW-1:0]     best_frac_q;
	logic              best_ok_q;
	logic              oor_q;

	logic             range_bad, below, exp_full, int_ovf;
	logic [PFD_W:0]   sum;
	logic             wrap;
	logic [PFD_W-1:0] r1_next;
	logic [MW-1:0]    m_next;
	logic [MW-1:0]    frac_next;
	logic [INT_W-1:0] err_hi, err_pick;
	logic             use_hi, better, last_m, finish;
	logic [MW-1:0]    frac_pick;

	// Range checks on the (doubled) frequency
	always_comb begin
		range_bad = (f_q == '0) || (f_q > VCO_MAX_KHZ) || (pfd == '0);
		below     = f_q < VCO_MIN_KHZ;
		exp_full  = exp_q == EXP_W'(MAX_DIVIDER_EXP);
		int_ovf   = PFD_W'(f_q[FREQ_W-1:INT_W]) >= pfd;
	end

	// Next modulus: remainder of rem*m/pfd kept incrementally
	always_comb begin
		sum       = {1'b0, r1_q} + {1'b0, rem_q};
		wrap      = sum >= {1'b0, pfd};
		r1_next   = wrap ? PFD_W'(sum - {1'b0, pfd}) : sum[PFD_W-1:0];
		m_next    = m_q + 1'b1;
		frac_next = frac_q + MW'(wrap);
	end

	// Candidate pick: floor error is ceil(r1/m), round-up error is (pfd-r1)/m
	always_comb begin
		err_hi    = div_rsp.quotient;
		use_hi    = err_hi < err_lo_q;
		err_pick  = use_hi ? err_hi : err_lo_q;
		frac_pick = use_hi ? frac_q + 1'b1 : frac_q;
		better    = !best_ok_q || (err_pick < best_err_q);
		last_m    = m_q == MW'(MOD_LIMIT - 1);
		finish    = (better && (err_pick == '0)) || last_m;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RANGE;
			end
			ST_RANGE: begin
				priority if (range_bad) state_d = ST_DONE;
				else if (below && exp_full) state_d = ST_DONE;
				else if (below) state_d = ST_RANGE;
				else if (int_ovf) state_d = ST_DONE;
				else state_d = ST_INT_WAIT;
			end
			ST_INT_WAIT: begin
				if (div_rsp.done) state_d = ST_STEP;
			end
			ST_STEP: state_d = ST_LO_WAIT;
			ST_LO_WAIT: begin
				if (div_rsp.done) state_d = ST_HI_WAIT;
			end
			ST_HI_WAIT: begin
				if (div_rsp.done) state_d = finish ? ST_DONE : ST_STEP;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshakes and divider requests
	always_comb begin
		in_ready         = 1'b0;
		res_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = f_q;
		div_req.divisor  = pfd;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_RANGE: begin
				div_req.start = !range_bad && !below && !int_ovf;
			end
			ST_STEP: begin
				div_req.start    = 1'b1;
				div_req.dividend = FREQ_W'(r1_next);
				div_req.divisor  = PFD_W'(m_next);
			end
			ST_LO_WAIT: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = FREQ_W'(pfd - r1_q);
				div_req.divisor  = PFD_W'(m_q);
			end
			ST_DONE: res_valid = 1'b1;
			ST_INT_WAIT, ST_HI_WAIT: ;
			default: ;
		endcase
	end

	// State register and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			best_ok_q <= 1'b0;
			oor_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				best_ok_q <= 1'b0;
				oor_q     <= 1'b0;
			end
			if (state_q == ST_RANGE &&
				(range_bad || (below && exp_full) || (!below && int_ovf)))
				oor_q <= 1'b1;
			if (state_q == ST_HI_WAIT && div_rsp.done && better)
				best_ok_q <= 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					f_q   <= in_target;
					exp_q <= '0;
				end
			end
			ST_RANGE: begin
				if (!range_bad && below && !exp_full) begin
					f_q   <= {f_q[FREQ_W-2:0], 1'b0};
					exp_q <= exp_q + 1'b1;
				end
			end
			ST_INT_WAIT: begin
				if (div_rsp.done) begin
					int_q  <= div_rsp.quotient;
					rem_q  <= div_rsp.remainder;
					r1_q   <= div_rsp.remainder;
					m_q    <= MW'(1);
					frac_q <= '0;
				end
			end
			ST_STEP: begin
				r1_q   <= r1_next;
				m_q    <= m_next;
				frac_q <= frac_next;
			end
			ST_LO_WAIT: begin
				if (div_rsp.done)
					err_lo_q <= div_rsp.quotient + INT_W'(div_rsp.remainder != '0);
			end
			ST_HI_WAIT: begin
				if (div_rsp.done && better) begin
					best_err_q  <= err_pick;
					best_m_q    <= m_q;
					best_frac_q <= frac_pick;
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// Result; all other fields zero when out of range
	always_comb begin
		res = '0;
		res.out_of_range = oor_q;
		if (!oor_q) begin
			res.integer_part       = int_q;
			res.fraction_value     = FIELD_W'(best_frac_q);
			res.modulus_value      = FIELD_W'(best_m_q);
			res.divider_exponent   = exp_q;
			res.residual_error_khz = best_err_q[ERR_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");
	a_frac_le_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.out_of_range) |->
		(res.fraction_value <= res.modulus_value) && (res.modulus_value >= FIELD_W'(2)))
		else $error("result fraction or modulus out of range");
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.out_of_range) |->
		(res.integer_part == '0) && (res.modulus_value == '0) && (res.fraction_value == '0))
		else $error("out-of-range result carries nonzero fields");
	a_rem_below_pfd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (rem_q < pfd) && (r1_q < pfd))
		else $error("integer split remainder not below pfd");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(res))
		else $error("result changed while waiting for output slot");
`endif

endmodule
